// ===== rtl/tlcg_pkg.sv =====
// Package for the tally LED colour generator: constants, codes, sequencer states
// and the raised-sine table that is built at elaboration.
// Depends on nothing; every other file imports it.
package tlcg_pkg;

    localparam int UPDATE_INTERVAL_MS = 20;
    localparam int SINE_DEPTH         = 256;
    localparam int SINE_IDX_W         = $clog2(SINE_DEPTH);

    localparam int NOW_W     = 32;
    localparam int PERIOD_W  = 12;     // breath_period * 10 fits below 4096
    localparam int STEP_W    = 5;
    localparam int PROD_W    = 15;     // 8-bit value times 7-bit percent
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 32768
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 8'd3;

    // Mode codes
    localparam logic [2:0] MODE_PROGRAM_RED   = 3'd0;
    localparam logic [2:0] MODE_PREVIEW_GREEN = 3'd1;
    localparam logic [2:0] MODE_STANDBY_WHITE = 3'd2;
    localparam logic [2:0] MODE_AMBER_BREATH  = 3'd3;
    localparam logic [2:0] MODE_WHITE_BREATH  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_IDX,
        ST_ROM,
        ST_MUL,
        ST_DIV100,
        ST_FINISH
    } tlcg_state_t;

    typedef logic [SINE_DEPTH-1:0][7:0] sine_rom_t;

    // cos(x) in Q30 for x in [0, pi/2], clamped to [0, 1.0]
    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2, t2, t4, t6, t8, t10, pos, neg, c;
        x2  = (x * x) >> 30;
        t2  = x2 / 64'd2;
        t4  = ((t2 * x2) >> 30) / 64'd12;
        t6  = ((t4 * x2) >> 30) / 64'd30;
        t8  = ((t6 * x2) >> 30) / 64'd56;
        t10 = ((t8 * x2) >> 30) / 64'd90;
        pos = Q30_ONE + t4 + t8;
        neg = t2 + t6 + t10;
        c   = (pos > neg) ? pos - neg : 64'd0;
        return (c > Q30_ONE) ? Q30_ONE : c;
    endfunction

    function automatic logic [7:0] raised_sine(input int i);
        int          k, quad, r;
        logic [63:0] a, b, v, lvl;
        k    = i * 4;
        quad = (k / SINE_DEPTH) & 3;
        r    = k % SINE_DEPTH;
        a    = (64'(r) * Q30_HALF_PI) / 64'(SINE_DEPTH);
        b    = (quad == 1 || quad == 3) ? Q30_HALF_PI - a : a;
        v    = cos_q30(b);
        if (quad == 1 || quad == 2)
        begin
            lvl = ((Q30_ONE + v) * 64'd255) >> 31;
        end
        else
        begin
            lvl = ((Q30_ONE - v) * 64'd255) >> 31;
        end
        return (lvl > 64'd255) ? 8'd255 : lvl[7:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            rom[i] = raised_sine(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/tlcg_ifs.sv =====
// Valid/ready channel interfaces for the tally LED colour generator:
// timestamp words in, colour words out, register writes.
// Depends on tlcg_pkg for widths.
interface tlcg_sample_if
    import tlcg_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface tlcg_colour_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface tlcg_cfg_if
    import tlcg_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tally_led_colour_generator_top.sv =====
// Tally LED colour generator: one timestamp word in, at most one colour word out.
// From acceptance to colour valid the sequencer runs 32 remainder steps, 8 phase
// steps, a table read, two scaling steps and the load; a zero period skips both passes.
// A new word is accepted only in idle, after the last colour word is loaded.
// Reset: registers take mode 3, brightness 80, standby 20, period 40; last update 0.
// Depends on tlcg_pkg and the interfaces in tlcg_ifs.sv.
module tally_led_colour_generator_top
    import tlcg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    tlcg_sample_if.sink     sample,
    tlcg_colour_if.source   colour,
    tlcg_cfg_if.sink        cfg
);

    // ------------------------------------------------------------------
    // Configuration registers: always ready, writes beyond the list drop.
    // ------------------------------------------------------------------
    logic [2:0] mode_reg;
    logic [6:0] brightness_reg;
    logic [6:0] standby_reg;
    logic [7:0] period_cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_AMBER_BREATH;
            brightness_reg <= 7'd80;
            standby_reg    <= 7'd20;
            period_cfg_reg <= 8'd40;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODE:       mode_reg       <= cfg.data[2:0];
                REG_BRIGHTNESS: brightness_reg <= cfg.data[6:0];
                REG_STANDBY:    standby_reg    <= cfg.data[6:0];
                REG_PERIOD:     period_cfg_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    tlcg_state_t          state_reg, state_next;
    logic [NOW_W-1:0]     last_reg, last_next;
    logic [NOW_W-1:0]     dvd_reg, dvd_next;     // dividend, shifted out msb first
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [SINE_IDX_W-1:0] idx_reg, idx_next;    // phase quotient
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [7:0]           level_reg, level_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [7:0]           scaled_reg, scaled_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           red_reg, red_next;
    logic [7:0]           green_reg, green_next;
    logic [7:0]           blue_reg, blue_next;

    // Breathing period in ms: bp * 10 = bp * 8 + bp * 2
    logic [PERIOD_W-1:0] period;
    assign period = {1'b0, period_cfg_reg, 3'b000} + {3'b000, period_cfg_reg, 1'b0};

    // Gate on the update interval, modulo 2^32
    logic [NOW_W-1:0] delta;
    logic             too_early;
    assign delta     = sample.now_ms - last_reg;
    assign too_early = (delta < NOW_W'(UPDATE_INTERVAL_MS));

    // Shared compare-subtract unit: one restoring division step.
    // During the remainder pass the next dividend bit shifts in; during the
    // phase pass a zero shifts in (remainder * 2, one quotient bit a step).
    logic                bit_in;
    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W+1:0] diff;
    logic                fits;
    logic [PERIOD_W-1:0] step_rem;

    assign bit_in   = (state_reg == ST_MOD) ? dvd_reg[NOW_W-1] : 1'b0;
    assign trial    = {rem_reg, bit_in};
    assign diff     = {1'b0, trial} - {2'b00, period};
    assign fits     = !diff[PERIOD_W+1];
    assign step_rem = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

    // Scaling: value * percent, then divide by 100 through the reciprocal
    logic [7:0]               mul_value;
    logic [6:0]               mul_pct;
    logic [PROD_W+12:0]       recip_prod;
    logic [PROD_W+12-RECIP_SHIFT:0] quot100;
    logic [9:0]               amber_g;

    assign recip_prod = {13'd0, prod_reg} * (PROD_W + 13)'(RECIP_100);
    assign quot100    = recip_prod[PROD_W+12:RECIP_SHIFT];
    assign amber_g    = ({2'b00, scaled_reg} * 10'd3) >> 3;   // scaled * 96 / 256

    always_comb
    begin
        case (mode_reg)
            MODE_PROGRAM_RED, MODE_PREVIEW_GREEN:
            begin
                mul_value = 8'd255;
                mul_pct   = brightness_reg;
            end
            MODE_STANDBY_WHITE:
            begin
                mul_value = 8'd255;
                mul_pct   = standby_reg;
            end
            default:
            begin
                mul_value = level_reg;
                mul_pct   = brightness_reg;
            end
        endcase
    end

    logic load_out;

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        level_next     = level_reg;
        prod_next      = prod_reg;
        scaled_next    = scaled_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        load_out       = 1'b0;
        sample.ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
                // Drop words that arrive inside the update interval
                if (sample.valid && !too_early)
                begin
                    last_next = sample.now_ms;
                    dvd_next  = sample.now_ms;
                    rem_next  = '0;
                    idx_next  = '0;
                    step_next = STEP_W'(NOW_W - 1);
                    if (period == '0)
                    begin
                        state_next = ST_ROM;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next = step_rem;
                dvd_next = {dvd_reg[NOW_W-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    step_next  = STEP_W'(SINE_IDX_W - 1);
                    state_next = ST_IDX;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_IDX:
            begin
                rem_next = step_rem;
                idx_next = {idx_reg[SINE_IDX_W-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = ST_ROM;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_ROM:
            begin
                level_next = SINE_ROM[idx_reg];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = {7'd0, mul_value} * {8'd0, mul_pct};
                state_next = ST_DIV100;
            end
            ST_DIV100:
            begin
                // Saturate: a percent above 100 can pass 255
                scaled_next = (quot100 > 9'(255)) ? 8'd255 : quot100[7:0];
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hold here until the output register is free
                if (!out_valid_reg || colour.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    red_next   = 8'd0;
                    green_next = 8'd0;
                    blue_next  = 8'd0;
                    case (mode_reg)
                        MODE_PROGRAM_RED:   red_next = scaled_reg;
                        MODE_PREVIEW_GREEN: green_next = scaled_reg;
                        MODE_STANDBY_WHITE, MODE_WHITE_BREATH:
                        begin
                            red_next   = scaled_reg;
                            green_next = scaled_reg;
                            blue_next  = scaled_reg;
                        end
                        MODE_AMBER_BREATH:
                        begin
                            red_next   = scaled_reg;
                            green_next = amber_g[7:0];
                        end
                        default: ;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (colour.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        idx_reg    <= idx_next;
        level_reg  <= level_next;
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
    end

    assign colour.valid = out_valid_reg;
    assign colour.red   = red_reg;
    assign colour.green = green_reg;
    assign colour.blue  = blue_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A word inside the update interval leaves the sequencer idle
    a_drop_early: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready && too_early) |=> (state_reg == ST_IDLE))
        else $error("early timestamp started the sequencer");

    // The phase pass always works on a remainder below the period
    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDX) |-> (rem_reg < period))
        else $error("remainder not below period in phase pass");

    // A new colour word appears only from the final sequencer step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("colour word raised outside the final step");

    // The last remainder step hands over to the phase pass
    a_mod_to_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD && step_reg == '0) |=> (state_reg == ST_IDX))
        else $error("remainder pass did not hand over");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the tally LED colour generator.
// Drives timestamp words and register writes, predicts each colour word and
// checks it; depends on tlcg_pkg, the interfaces in tlcg_ifs.sv and the top level.
module tb_top;
    import tlcg_pkg::*;

    // Timing of the run
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 80;     // comfortably above the sequencer's run from acceptance to colour valid
    localparam int RESET_CYCLES  = 8;

    // Behaviour of the block, restated for the prediction
    localparam int unsigned REFRESH_MS      = 20;
    localparam int unsigned CURVE_DEPTH     = 256;
    localparam int unsigned FULL_SCALE      = 255;
    localparam int unsigned AMBER_GREEN_MUL = 96;
    localparam int unsigned PERIOD_UNIT_MS  = 10;
    localparam logic [63:0] FIX_ONE         = 64'd1 << 30;
    localparam logic [63:0] FIX_QUARTER_TURN = 64'd1686629713;

    // Mode codes the block does not define, and register indexes it ignores
    localparam logic [2:0]           MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]           MODE_UNUSED_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND        = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_BEYOND    = 8'hFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tlcg_sample_if sample_ch ();
    tlcg_colour_if colour_ch ();
    tlcg_cfg_if    cfg_ch ();

    tally_led_colour_generator_top uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .colour (colour_ch),
        .cfg    (cfg_ch)
    );

    // Shadow of the block: register copies, last refresh time and the level curve
    logic [2:0]  shadow_mode;
    logic [6:0]  shadow_bright;
    logic [6:0]  shadow_standby;
    logic [7:0]  shadow_period;
    logic [31:0] last_stamp;
    logic [7:0]  breath_curve [CURVE_DEPTH];

    colour_t     pending_colours [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_off_cycles = 0;
    bit          gaps_on   = 1'b1;
    bit          stalls_on = 1'b1;
    logic [31:0] stamp;

    always #2 clk = ~clk;

    // Watchdog: a hung handshake or a missing colour word ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Raised-sine level for one curve entry, cosine from a Q30 Taylor series
    // on an angle folded into the first quadrant.
    function automatic logic [7:0] raised_level(input int unsigned entry);
        int unsigned quarter, offset;
        logic [63:0] angle, ang_sq, term, plus_sum, minus_sum, cosine, lvl;
        quarter = ((entry * 4) / CURVE_DEPTH) & 3;
        offset  = (entry * 4) % CURVE_DEPTH;
        angle   = (64'(offset) * FIX_QUARTER_TURN) / 64'(CURVE_DEPTH);
        if (quarter == 1 || quarter == 3)
        begin
            angle = FIX_QUARTER_TURN - angle;
        end
        ang_sq    = (angle * angle) >> 30;
        term      = ang_sq / 64'd2;
        minus_sum = term;
        plus_sum  = FIX_ONE;
        // each further term is the previous one times x^2 / ((2k+3)(2k+4))
        for (int k = 0; k < 4; k++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * k + 3) * (2 * k + 4));
            if (k % 2 == 0)
            begin
                plus_sum = plus_sum + term;
            end
            else
            begin
                minus_sum = minus_sum + term;
            end
        end
        cosine = (plus_sum > minus_sum) ? plus_sum - minus_sum : 64'd0;
        if (cosine > FIX_ONE)
        begin
            cosine = FIX_ONE;
        end
        if (quarter == 1 || quarter == 2)
        begin
            lvl = ((FIX_ONE + cosine) * 64'(FULL_SCALE)) >> 31;
        end
        else
        begin
            lvl = ((FIX_ONE - cosine) * 64'(FULL_SCALE)) >> 31;
        end
        return (lvl > 64'(FULL_SCALE)) ? 8'(FULL_SCALE) : lvl[7:0];
    endfunction

    function automatic logic [7:0] percent_of(input int unsigned value, input int unsigned pct);
        int unsigned scaled;
        scaled = (value * pct) / 100;
        return (scaled > FULL_SCALE) ? 8'(FULL_SCALE) : scaled[7:0];
    endfunction

    // Colour caused by one timestamp word; returns 0 when the refresh interval
    // has not yet run out. Advances the last refresh time as the block does.
    function automatic bit colour_for_stamp(input logic [31:0] stamp_in, output colour_t hue);
        logic [31:0] since, span;
        int unsigned phase_idx;
        logic [7:0]  dimmed;
        hue   = '0;
        since = stamp_in - last_stamp;
        if (since < REFRESH_MS)
        begin
            return 1'b0;
        end
        last_stamp = stamp_in;
        span       = 32'(shadow_period) * PERIOD_UNIT_MS;
        phase_idx  = (span == 0) ? 0 : ((stamp_in % span) * CURVE_DEPTH) / span;
        if (phase_idx >= CURVE_DEPTH)
        begin
            phase_idx = CURVE_DEPTH - 1;
        end
        dimmed = percent_of(breath_curve[phase_idx], shadow_bright);
        case (shadow_mode)
            MODE_PROGRAM_RED:   hue.red   = percent_of(FULL_SCALE, shadow_bright);
            MODE_PREVIEW_GREEN: hue.green = percent_of(FULL_SCALE, shadow_bright);
            MODE_STANDBY_WHITE:
            begin
                hue.red   = percent_of(FULL_SCALE, shadow_standby);
                hue.green = hue.red;
                hue.blue  = hue.red;
            end
            MODE_AMBER_BREATH:
            begin
                hue.red   = dimmed;
                hue.green = 8'((32'(dimmed) * AMBER_GREEN_MUL) >> 8);
            end
            MODE_WHITE_BREATH:
            begin
                hue.red   = dimmed;
                hue.green = dimmed;
                hue.blue  = dimmed;
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0d] %s", cycle_count, what);
        end
    endtask

    // Compare every colour word taken by the receiver with the oldest prediction
    always @(posedge clk)
    begin
        colour_t seen;
        colour_t want;
        if (rst_n && colour_ch.valid && colour_ch.ready)
        begin
            seen = {colour_ch.red, colour_ch.green, colour_ch.blue};
            if (pending_colours.size() == 0)
            begin
                report_failure($sformatf("unexpected colour word r=%0d g=%0d b=%0d",
                                         seen.red, seen.green, seen.blue));
            end
            else
            begin
                want = pending_colours.pop_front();
                if (seen.red !== want.red || seen.green !== want.green
                    || seen.blue !== want.blue)
                begin
                    report_failure($sformatf(
                        "colour mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        want.red, want.green, want.blue, seen.red, seen.green, seen.blue));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        int unsigned span;
        colour_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                // hold off for the whole stretch so the block backs up into its input
                span = hold_off_cycles;
                hold_off_cycles = 0;
                colour_ch.ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                colour_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                colour_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one timestamp word, optionally after a gap; leave valid high on
    // return so a back-to-back word needs no second assignment in the step.
    task automatic send_sample(input logic [31:0] when_ms);
        colour_t hue;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.now_ms <= when_ms;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        if (colour_for_stamp(when_ms, hue))
        begin
            pending_colours.push_back(hue);
        end
    endtask

    // Drop valid, wait for every predicted colour, then let the block go quiet
    // (a word that causes no colour may still be in flight).
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (pending_colours.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; valid stays high so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        case (idx)
            REG_MODE:       shadow_mode    = data[2:0];
            REG_BRIGHTNESS: shadow_bright  = data[6:0];
            REG_STANDBY:    shadow_standby = data[6:0];
            REG_PERIOD:     shadow_period  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] mode_d, input logic [7:0] bright_d,
                              input logic [7:0] standby_d, input logic [7:0] period_d);
        settle();
        write_reg(REG_MODE, mode_d);
        write_reg(REG_BRIGHTNESS, bright_d);
        write_reg(REG_STANDBY, standby_d);
        write_reg(REG_PERIOD, period_d);
        cfg_ch.valid <= 1'b0;
    endtask

    // Pick a percentage, favouring off, full and the saturating top code
    function automatic logic [7:0] pick_percent();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd100;
            2:       return 8'd127;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_period();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly steady time with refresh-sized steps; some short steps that must
    // be ignored, some jumps anywhere, and some runs up to the 32-bit wrap.
    task automatic advance_stamp();
        case ($urandom_range(0, 9))
            0, 1:    stamp = stamp + $urandom_range(0, REFRESH_MS - 1);
            2:       stamp = $urandom();
            3:       stamp = 32'hFFFF_FFFF - $urandom_range(0, 300);
            default: stamp = stamp + $urandom_range(REFRESH_MS, 400);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Last refresh starts at zero, so early words are dropped until 20 ms
    task automatic test_early_stamps();
        send_sample(32'd0);
        send_sample(32'd7);
        send_sample(32'd19);
        send_sample(32'd20);
        send_sample(32'd31);
        send_sample(32'd39);
        send_sample(32'd40);
        stamp = 32'd40;
    endtask

    // Solid and unused mode codes, full and zero brightness, saturating percentages
    task automatic test_solid_modes();
        set_config(8'(MODE_PROGRAM_RED), 8'd100, 8'd20, 8'd40);
        stamp += 1000;
        send_sample(stamp);
        set_config(8'(MODE_PREVIEW_GREEN), 8'd127, 8'd20, 8'd40);
        stamp += 1000;
        send_sample(stamp);
        set_config(8'(MODE_STANDBY_WHITE), 8'd80, 8'd0, 8'd40);
        stamp += 1000;
        send_sample(stamp);
        set_config(8'(MODE_STANDBY_WHITE), 8'd80, 8'd127, 8'd40);
        stamp += 1000;
        send_sample(stamp);
        set_config(8'(MODE_PROGRAM_RED), 8'd0, 8'd20, 8'd40);
        stamp += 1000;
        send_sample(stamp);
        for (logic [3:0] m = 4'(MODE_UNUSED_FIRST); m <= 4'(MODE_UNUSED_LAST); m++)
        begin
            set_config(8'(m), 8'd100, 8'd100, 8'd40);
            stamp += 1000;
            send_sample(stamp);
        end
    endtask

    // Zero, longest and shortest breathing periods; the top timestamp and the wrap
    task automatic test_breath_edges();
        set_config(8'(MODE_AMBER_BREATH), 8'd100, 8'd20, 8'd0);
        send_sample(32'd12345);
        set_config(8'(MODE_WHITE_BREATH), 8'd127, 8'd20, 8'd255);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0012);     // 19 ms across the wrap: ignored
        send_sample(32'h0000_0013);     // 20 ms across the wrap: refresh
        set_config(8'(MODE_WHITE_BREATH), 8'd100, 8'd20, 8'd1);
        send_sample(32'h8000_0005);
        send_sample(32'h8000_0019);
        stamp = 32'h8000_0019;
    endtask

    // Upper data bits are dropped and unknown indexes leave everything alone
    task automatic test_register_masking();
        settle();
        write_reg(REG_MODE, 8'hFC);
        write_reg(REG_BRIGHTNESS, 8'hE4);
        write_reg(REG_STANDBY, 8'hFF);
        write_reg(REG_PERIOD, 8'hC8);
        write_reg(REG_BEYOND, 8'h00);
        write_reg(REG_FAR_BEYOND, 8'h01);
        cfg_ch.valid <= 1'b0;
        stamp += 777;
        send_sample(stamp);
        stamp += 1234;
        send_sample(stamp);
    endtask

    task automatic test_random_traffic(input int phases, input int words_per_phase);
        for (int p = 0; p < phases; p++)
        begin
            set_config(8'($urandom_range(0, 255)), pick_percent(), pick_percent(), pick_period());
            for (int n = 0; n < words_per_phase; n++)
            begin
                advance_stamp();
                send_sample(stamp);
            end
        end
    endtask

    // Hold the receiver off while words keep coming, so the input stalls
    task automatic test_back_pressure();
        set_config(8'(MODE_WHITE_BREATH), pick_percent(), pick_percent(), pick_period());
        hold_off_cycles = 600;
        for (int n = 0; n < 20; n++)
        begin
            stamp = stamp + $urandom_range(REFRESH_MS, 100);
            send_sample(stamp);
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        sample_ch.valid  <= 1'b0;
        sample_ch.now_ms <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;

        // reset values of the block
        shadow_mode    = MODE_AMBER_BREATH;
        shadow_bright  = 7'd80;
        shadow_standby = 7'd20;
        shadow_period  = 8'd40;
        last_stamp     = '0;
        stamp          = '0;
        for (int i = 0; i < CURVE_DEPTH; i++)
        begin
            breath_curve[i] = raised_level(i);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_early_stamps();
        test_solid_modes();
        test_breath_edges();
        test_register_masking();
        test_random_traffic(9, 90);
        test_back_pressure();

        // final stretch at full rate on both sides
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_traffic(1, 150);

        settle();
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
